// ===== src/tga_pkg.sv =====
package tga_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_file;
   } req_type;

   typedef struct packed {
      logic [7:0]  chan0;
      logic [7:0]  chan1;
      logic [7:0]  chan2;
      logic [7:0]  chan3;
      logic [7:0]  run_count;
      logic [2:0]  channel_count;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        last_pixel;
      logic [1:0]  error_code;
   } rsp_type;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_TYPE     = 2'd1;
   localparam logic [1:0] ERR_CHANNELS = 2'd2;

endpackage

// ===== src/tga_core.sv =====
module tga_core
   import tga_pkg::*;
#(
   parameter int MAX_CHANNELS = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_take,
   input  req_type in_item,
   output logic    res_valid,
   output rsp_type res_item
);

   typedef enum logic [5:0] {
      PH_HEADER = 6'b000001,
      PH_SKIP   = 6'b000010,
      PH_PACKET = 6'b000100,
      PH_PIXEL  = 6'b001000,
      PH_DONE   = 6'b010000,
      PH_ERROR  = 6'b100000
   } phase_type;

   localparam logic [7:0] KIND_RAW = 8'd2;
   localparam logic [7:0] KIND_RLE = 8'd10;

   localparam logic [4:0] HDR_ID_LEN  = 5'd0;
   localparam logic [4:0] HDR_MAP     = 5'd1;
   localparam logic [4:0] HDR_KIND    = 5'd2;
   localparam logic [4:0] HDR_MLEN_LO = 5'd5;
   localparam logic [4:0] HDR_MLEN_HI = 5'd6;
   localparam logic [4:0] HDR_W_LO    = 5'd12;
   localparam logic [4:0] HDR_W_HI    = 5'd13;
   localparam logic [4:0] HDR_H_LO    = 5'd14;
   localparam logic [4:0] HDR_H_HI    = 5'd15;
   localparam logic [4:0] HDR_DEPTH   = 5'd16;
   localparam logic [4:0] HDR_LAST    = 5'd17;

   localparam logic [7:0] RUN_FLAG = 8'h80;
   localparam logic [7:0] RUN_MASK = 8'h7f;

   phase_type       phase_ff, phase_in, phase_cur;
   logic [4:0]      hidx_ff, hidx_in, hidx_cur;
   logic [7:0]      id_len_ff, id_len_in, id_len_cur;
   logic [7:0]      map_type_ff, map_type_in, map_type_cur;
   logic [15:0]     map_len_ff, map_len_in, map_len_cur;
   logic [7:0]      kind_ff, kind_in, kind_cur;
   logic [15:0]     width_ff, width_in, width_cur;
   logic [15:0]     height_ff, height_in, height_cur;
   logic [7:0]      depth_ff, depth_in, depth_cur;
   logic [23:0]     skip_ff, skip_in, skip_cur;
   logic [7:0]      pkt_left_ff, pkt_left_in, pkt_left_cur;
   logic            pkt_run_ff, pkt_run_in, pkt_run_cur;
   logic [3:0][7:0] pix_ff, pix_in;
   logic [2:0]      bip_ff, bip_in, bip_cur;
   logic [31:0]     pix_left_ff, pix_left_in, pix_left_cur;

   logic            sof;
   logic [7:0]      b;
   logic [4:0]      chans;
   logic [3:0]      bip_next;
   logic [7:0]      run;
   logic [23:0]     map_bytes;
   logic [31:0]     area;
   phase_type       data_phase;

   function automatic rsp_type fill(input logic [3:0][7:0] pb, input logic [4:0] c,
                                    input logic [15:0] w, input logic [15:0] h,
                                    input logic [7:0] r, input logic l,
                                    input logic [1:0] e);
      rsp_type    o;
      logic [7:0] bv [4];
      logic [7:0] t;
      for (int k = 0; k < 4; k++) begin
         bv[k] = ((5'(k) < c) && (e == ERR_NONE)) ? pb[k] : 8'd0;
      end
      if ((c == 5'd3) && (e == ERR_NONE)) begin
         t     = bv[0];
         bv[0] = bv[2];
         bv[2] = t;
      end
      o.chan0         = bv[0];
      o.chan1         = bv[1];
      o.chan2         = bv[2];
      o.chan3         = bv[3];
      o.run_count     = r;
      o.channel_count = c[2:0];
      o.image_width   = w;
      o.image_height  = h;
      o.last_pixel    = l;
      o.error_code    = e;
      return o;
   endfunction

   assign sof = in_item.start_of_file;
   assign b   = in_item.data_byte;

   always_comb begin
      phase_cur    = sof ? PH_HEADER : phase_ff;
      hidx_cur     = sof ? 5'd0 : hidx_ff;
      id_len_cur   = sof ? 8'd0 : id_len_ff;
      map_type_cur = sof ? 8'd0 : map_type_ff;
      map_len_cur  = sof ? 16'd0 : map_len_ff;
      kind_cur     = sof ? 8'd0 : kind_ff;
      width_cur    = sof ? 16'd0 : width_ff;
      height_cur   = sof ? 16'd0 : height_ff;
      depth_cur    = sof ? 8'd0 : depth_ff;
      skip_cur     = sof ? 24'd0 : skip_ff;
      pkt_left_cur = sof ? 8'd0 : pkt_left_ff;
      pkt_run_cur  = sof ? 1'b0 : pkt_run_ff;
      bip_cur      = sof ? 3'd0 : bip_ff;
      pix_left_cur = sof ? 32'd0 : pix_left_ff;
   end

   assign chans      = depth_cur[7:3];
   assign data_phase = (kind_cur == KIND_RLE) ? PH_PACKET : PH_PIXEL;
   assign map_bytes  = {16'd0, map_type_cur} * {8'd0, map_len_cur};
   assign area       = {16'd0, width_cur} * {16'd0, height_cur};
   assign bip_next   = {1'b0, bip_cur} + 4'd1;

   always_comb begin
      phase_in    = phase_cur;
      hidx_in     = hidx_cur;
      id_len_in   = id_len_cur;
      map_type_in = map_type_cur;
      map_len_in  = map_len_cur;
      kind_in     = kind_cur;
      width_in    = width_cur;
      height_in   = height_cur;
      depth_in    = depth_cur;
      skip_in     = skip_cur;
      pkt_left_in = pkt_left_cur;
      pkt_run_in  = pkt_run_cur;
      pix_in      = pix_ff;
      bip_in      = bip_cur;
      pix_left_in = pix_left_cur;
      run         = 8'd1;
      res_valid   = 1'b0;
      res_item    = fill(pix_ff, chans, width_cur, height_cur, 8'd0, 1'b0, ERR_NONE);
      case (phase_cur)
         PH_HEADER: begin
            case (hidx_cur)
               HDR_ID_LEN:  id_len_in   = b;
               HDR_MAP:     map_type_in = b;
               HDR_KIND:    kind_in     = b;
               HDR_MLEN_LO: map_len_in  = {map_len_cur[15:8], b};
               HDR_MLEN_HI: map_len_in  = {b, map_len_cur[7:0]};
               HDR_W_LO:    width_in    = {width_cur[15:8], b};
               HDR_W_HI:    width_in    = {b, width_cur[7:0]};
               HDR_H_LO:    height_in   = {height_cur[15:8], b};
               HDR_H_HI:    height_in   = {b, height_cur[7:0]};
               HDR_DEPTH: begin
                  depth_in    = b;
                  skip_in     = {16'd0, id_len_cur} + map_bytes;
                  pix_left_in = area;
               end
               default: ;
            endcase
            if (hidx_cur < HDR_LAST) begin
               hidx_in = hidx_cur + 5'd1;
            end else begin
               hidx_in = 5'd0;
               if ((kind_cur != KIND_RAW) && (kind_cur != KIND_RLE)) begin
                  phase_in  = PH_ERROR;
                  res_valid = 1'b1;
                  res_item  = fill(pix_ff, chans, width_cur, height_cur, 8'd0, 1'b0,
                                   ERR_TYPE);
               end else if ((chans == 5'd0) || (chans > 5'(MAX_CHANNELS))) begin
                  phase_in  = PH_ERROR;
                  res_valid = 1'b1;
                  res_item  = fill(pix_ff, chans, width_cur, height_cur, 8'd0, 1'b0,
                                   ERR_CHANNELS);
               end else begin
                  pkt_left_in = 8'd0;
                  pkt_run_in  = 1'b0;
                  bip_in      = 3'd0;
                  if (pix_left_cur == 32'd0) begin
                     phase_in = PH_DONE;
                  end else if (skip_cur != 24'd0) begin
                     phase_in = PH_SKIP;
                  end else begin
                     phase_in = data_phase;
                  end
               end
            end
         end
         PH_SKIP: begin
            if (skip_cur != 24'd0) begin
               skip_in = skip_cur - 24'd1;
            end
            if (skip_in == 24'd0) begin
               phase_in = data_phase;
            end
         end
         PH_PACKET: begin
            pkt_run_in  = (b & RUN_FLAG) != 8'd0;
            pkt_left_in = (b & RUN_MASK) + 8'd1;
            bip_in      = 3'd0;
            phase_in    = PH_PIXEL;
         end
         PH_PIXEL: begin
            if (bip_cur < 3'd4) begin
               pix_in[bip_cur[1:0]] = b;
            end
            if ({1'b0, bip_next} < chans) begin
               bip_in = bip_next[2:0];
            end else begin
               bip_in = 3'd0;
               if (kind_cur == KIND_RLE) begin
                  if (pkt_run_cur) begin
                     run = ({24'd0, pkt_left_cur} < pix_left_cur) ? pkt_left_cur
                                                                 : pix_left_cur[7:0];
                     pkt_left_in = 8'd0;
                  end else if (pkt_left_cur != 8'd0) begin
                     pkt_left_in = pkt_left_cur - 8'd1;
                  end
               end
               pix_left_in = pix_left_cur - {24'd0, run};
               if (pix_left_in == 32'd0) begin
                  phase_in = PH_DONE;
               end else if ((kind_cur == KIND_RLE) && (pkt_left_in == 8'd0)) begin
                  phase_in = PH_PACKET;
               end
               res_valid = 1'b1;
               res_item  = fill(pix_in, chans, width_cur, height_cur, run,
                                pix_left_in == 32'd0, ERR_NONE);
            end
         end
         default: ;
      endcase
      if (!in_take) begin
         res_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         hidx_ff     <= '0;
         id_len_ff   <= '0;
         map_type_ff <= '0;
         map_len_ff  <= '0;
         kind_ff     <= '0;
         width_ff    <= '0;
         height_ff   <= '0;
         depth_ff    <= '0;
         skip_ff     <= '0;
         pkt_left_ff <= '0;
         pkt_run_ff  <= 1'b0;
         bip_ff      <= '0;
         pix_left_ff <= '0;
      end else if (in_take) begin
         phase_ff    <= phase_in;
         hidx_ff     <= hidx_in;
         id_len_ff   <= id_len_in;
         map_type_ff <= map_type_in;
         map_len_ff  <= map_len_in;
         kind_ff     <= kind_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         depth_ff    <= depth_in;
         skip_ff     <= skip_in;
         pkt_left_ff <= pkt_left_in;
         pkt_run_ff  <= pkt_run_in;
         bip_ff      <= bip_in;
         pix_left_ff <= pix_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         pix_ff <= pix_in;
      end
   end

endmodule

// ===== src/tga_outbuf.sv =====
module tga_outbuf
   import tga_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    res_valid,
   input  rsp_type res_item,
   input  logic    rsp_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   output logic    full
);

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    out_free;

   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = res_valid;
            skid_data_in  = res_item;
         end else begin
            out_valid_in = res_valid;
            out_data_in  = res_item;
         end
      end else if (res_valid) begin
         // hold the waiting beat, park the new one
         skid_valid_in = 1'b1;
         skid_data_in  = res_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign full      = skid_valid_ff;

endmodule

// ===== src/tga_rle_image_decoder.sv =====
// TGA image decoder for raw (type 2) and run-length (type 10) images.
// req channel: one beat per file byte (req_data.data_byte), with
// req_data.start_of_file set on header byte 0 of each new file; the flag
// restarts parsing from any point. After reset the first byte is taken as
// header byte 0 even without the flag.
// rsp channel: one beat per decoded pixel or run (channel bytes, run count,
// header geometry, last_pixel), or one error beat on header byte 17 for an
// unsupported image type or channel count. Header, ID and color-map bytes
// and packet headers give no beat.
// Throughput: one byte per cycle while req_stall is low; every byte updates
// the parse registers in the cycle it is taken. A result is registered in
// the output register, or parked in the skid register while rsp is stalled.
// Stall: the output register is backed by a one-beat skid register; bytes
// keep being taken while a result is stalled until a second result is parked.
// req_stall rises only when the skid register holds a beat and falls once rsp
// drains it.
// Reset: synchronous, clears the parser to the header phase and empties
// both output registers.
module tga_rle_image_decoder
   import tga_pkg::*;
#(
   parameter int MAX_CHANNELS = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    in_take;
   logic    res_valid;
   rsp_type res_item;
   logic    full;

   assign in_take   = req_valid && !full;
   assign req_stall = full;

   tga_core #(
      .MAX_CHANNELS(MAX_CHANNELS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .in_take  (in_take),
      .in_item  (req_data),
      .res_valid(res_valid),
      .res_item (res_item)
   );

   tga_outbuf u_outbuf (
      .clock    (clock),
      .reset    (reset),
      .res_valid(res_valid),
      .res_item (res_item),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .full     (full)
   );

endmodule

// ===== src/tga_checker.sv =====
module tga_checker
   import tga_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp beat changed");

   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req stalled with no rsp beat pending");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("req stall rose without a stalled rsp beat");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output not empty after reset");

   a_error_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.error_code != ERR_NONE) |->
         (rsp_data.run_count == 8'd0) && !rsp_data.last_pixel)
      else $error("error beat carries pixel data");

endmodule

bind tga_rle_image_decoder tga_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);
